// ----- hdl/brb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_pkg
// Shared constants, operation codes and controller/datapath interface types
// for the byte ring buffer.
// ----------------------------------------------------------------------------
package brb_pkg;

   // Storage slots built into the block
   localparam int DEPTH = 1024;

   // Pointer and size widths follow from the storage depth
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int SIZE_W = PTR_W + 1;

   // Fixed field widths of the transaction ports
   localparam int OP_W     = 3;
   localparam int BYTE_W   = 8;
   localparam int OFFSET_W = 10;
   localparam int AMOUNT_W = 16;
   localparam int COUNT_W  = 10;
   localparam int CSR_W    = 11;

   // Width that holds any size, count or amount for comparisons
   localparam int WIDE_W = (SIZE_W > AMOUNT_W) ? SIZE_W : AMOUNT_W;

   // Remainder unit: one dividend bit per step
   localparam int DIV_STEPS = AMOUNT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Operation codes
   localparam logic [OP_W-1:0] OP_WRITE    = 3'd0;
   localparam logic [OP_W-1:0] OP_PEEK     = 3'd1;
   localparam logic [OP_W-1:0] OP_SKIP     = 3'd2;
   localparam logic [OP_W-1:0] OP_FLUSH    = 3'd3;
   localparam logic [OP_W-1:0] OP_SET_HEAD = 3'd4;
   localparam logic [OP_W-1:0] OP_SET_TAIL = 3'd5;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;     // capture the incoming transaction
      logic exec;       // evaluate the operation against the current pointers
      logic div_start;  // load the remainder unit
      logic div_step;   // advance the remainder unit by one bit
      logic commit;     // update pointers, storage and result register
   } brb_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic needs_div;  // pointer load that needs the remainder unit
   } brb_status_type;

endpackage

// ----- hdl/brb_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module brb_ram #(
   parameter int DATA_W    = 8,
   parameter int NUM_WORDS = 1024
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(NUM_WORDS)-1:0] wr_addr,
   input  logic [DATA_W-1:0]            wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(NUM_WORDS)-1:0] rd_addr,
   output logic [DATA_W-1:0]            rd_data
);

   logic [DATA_W-1:0] mem_ff [NUM_WORDS];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, hold data between reads
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/brb_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_ctrl
// Controller for the byte ring buffer: sequences each transaction through
// evaluate, optional remainder iteration and commit, and owns the result
// valid flag.
// ----------------------------------------------------------------------------
module brb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   input  brb_pkg::brb_status_type status,
   output brb_pkg::brb_cmd_type    cmd
);
   import brb_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_EXEC   = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 out_free;
   logic                 div_last;

   // Result register can take a new transaction when empty or draining
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign div_last = (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));

   // Next state and command decode
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            if (status.needs_div) begin
               cmd.div_start = 1'b1;
               cnt_in        = '0;
               state_in      = ST_DIVIDE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result valid: set on commit, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Never overwrite a result that is still held by a stalled receiver
   a_commit_free : assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !(rsp_valid_ff && rsp_stall))
      else $error("commit while result register is held");

   // An accepted transaction is evaluated in the next cycle
   a_accept_exec : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_EXEC))
      else $error("accepted transaction not evaluated");

   // Remainder iteration always runs its full step count
   a_div_len : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && !div_last) |=> (state_ff == ST_DIVIDE))
      else $error("remainder iteration cut short");

endmodule

// ----- hdl/brb_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// brb_datapath
// Datapath for the byte ring buffer: size register, head and tail pointers,
// byte storage, bit-serial remainder unit and the result register.
// ----------------------------------------------------------------------------
module brb_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  brb_pkg::brb_cmd_type          cmd,
   output brb_pkg::brb_status_type       status,
   input  logic [brb_pkg::OP_W-1:0]      req_operation,
   input  logic [brb_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic [brb_pkg::OFFSET_W-1:0]  req_peek_offset,
   input  logic [brb_pkg::AMOUNT_W-1:0]  req_amount,
   input  logic                          csr_write_enable,
   input  logic [brb_pkg::CSR_W-1:0]     csr_write_data,
   output logic [brb_pkg::BYTE_W-1:0]    rsp_read_byte,
   output logic                          rsp_ok,
   output logic [brb_pkg::COUNT_W-1:0]   rsp_readable_count,
   output logic [brb_pkg::COUNT_W-1:0]   rsp_writable_count
);
   import brb_pkg::*;

   // Bytes between tail and head on a ring of s slots
   function automatic logic [SIZE_W-1:0] readable(input logic [PTR_W-1:0] w,
                                                  input logic [PTR_W-1:0] r,
                                                  input logic [SIZE_W-1:0] s);
      if (w >= r) begin
         return SIZE_W'(w) - SIZE_W'(r);
      end
      return s - SIZE_W'(r) + SIZE_W'(w);
   endfunction

   // Control state
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [PTR_W-1:0]  wp_ff, wp_in;
   logic [PTR_W-1:0]  rp_ff, rp_in;

   // Captured transaction
   logic [OP_W-1:0]     op_ff;
   logic [BYTE_W-1:0]   data_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic [AMOUNT_W-1:0] amount_ff;

   // Evaluation results
   logic             ok_ff, ok_in;
   logic             store_ff, store_in;
   logic [PTR_W-1:0] wp_nx_ff, wp_nx_in;
   logic [PTR_W-1:0] rp_nx_ff, rp_nx_in;

   // Remainder unit
   logic [PTR_W-1:0]    rem_ff, rem_in;
   logic [AMOUNT_W-1:0] dvd_ff, dvd_in;
   logic [SIZE_W-1:0]   rem_trial;

   // Result register
   logic [BYTE_W-1:0]  byte_ff;
   logic               rok_ff;
   logic [COUNT_W-1:0] rcnt_ff, wcnt_ff;

   // Evaluation signals
   logic [SIZE_W-1:0] avail_old;
   logic              room;
   logic [SIZE_W-1:0] wp_inc;
   logic [PTR_W-1:0]  wp_wrap;
   logic              peek_ok;
   logic [SIZE_W-1:0] peek_sum;
   logic [PTR_W-1:0]  peek_addr;
   logic [SIZE_W-1:0] skip_n;
   logic [SIZE_W-1:0] skip_sum;
   logic [PTR_W-1:0]  skip_ptr;

   // Commit signals
   logic [PTR_W-1:0]  wp_new, rp_new;
   logic [SIZE_W-1:0] avail_new;
   logic [SIZE_W-1:0] free_new;
   logic [BYTE_W-1:0] ram_rd_data;

   assign status.needs_div = (op_ff == OP_SET_HEAD) || (op_ff == OP_SET_TAIL);

   // Capture the transaction
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= req_operation;
         data_ff   <= req_data_byte;
         offset_ff <= req_peek_offset;
         amount_ff <= req_amount;
      end
   end

   // Evaluate against the current pointers
   always_comb begin
      avail_old = readable(wp_ff, rp_ff, size_ff);
      room      = (avail_old != (size_ff - 1'b1));

      wp_inc  = SIZE_W'(wp_ff) + 1'b1;
      wp_wrap = (wp_inc == size_ff) ? '0 : wp_inc[PTR_W-1:0];

      peek_ok   = (WIDE_W'(offset_ff) < WIDE_W'(avail_old));
      peek_sum  = SIZE_W'(rp_ff) + SIZE_W'(offset_ff);
      peek_addr = (peek_sum >= size_ff) ? PTR_W'(peek_sum - size_ff) : PTR_W'(peek_sum);

      // Clip skip length to the readable count
      skip_n   = (WIDE_W'(amount_ff) > WIDE_W'(avail_old)) ? avail_old
                                                           : SIZE_W'(amount_ff);
      skip_sum = SIZE_W'(rp_ff) + skip_n;
      skip_ptr = (skip_sum >= size_ff) ? PTR_W'(skip_sum - size_ff) : PTR_W'(skip_sum);

      ok_in    = 1'b0;
      store_in = 1'b0;
      wp_nx_in = wp_ff;
      rp_nx_in = rp_ff;
      unique case (op_ff)
         OP_WRITE: begin
            ok_in    = room;
            store_in = room;
            if (room) begin
               wp_nx_in = wp_wrap;
            end
         end
         OP_PEEK: begin
            ok_in = peek_ok;
         end
         OP_SKIP: begin
            rp_nx_in = skip_ptr;
         end
         OP_FLUSH: begin
            rp_nx_in = wp_ff;
         end
         default: begin
            // pointer loads finish in the remainder unit; other codes do nothing
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         ok_ff    <= ok_in;
         store_ff <= store_in;
         wp_nx_ff <= wp_nx_in;
         rp_nx_ff <= rp_nx_in;
      end
   end

   // Remainder of amount by size, one dividend bit per step
   always_comb begin
      rem_trial = {rem_ff, dvd_ff[AMOUNT_W-1]};
      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      if (cmd.div_start) begin
         rem_in = '0;
         dvd_in = amount_ff;
      end else if (cmd.div_step) begin
         rem_in = (rem_trial >= size_ff) ? PTR_W'(rem_trial - size_ff)
                                         : PTR_W'(rem_trial);
         dvd_in = {dvd_ff[AMOUNT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   // Byte storage
   brb_ram #(
      .DATA_W    (BYTE_W),
      .NUM_WORDS (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.commit && store_ff),
      .wr_addr (wp_ff),
      .wr_data (data_ff),
      .rd_en   (cmd.exec && (op_ff == OP_PEEK)),
      .rd_addr (peek_addr),
      .rd_data (ram_rd_data)
   );

   // Pointers after the operation and the counts they give
   always_comb begin
      wp_new = (op_ff == OP_SET_HEAD) ? rem_ff : wp_nx_ff;
      rp_new = (op_ff == OP_SET_TAIL) ? rem_ff : rp_nx_ff;
      avail_new = readable(wp_new, rp_new, size_ff);
      free_new  = size_ff - 1'b1 - avail_new;
   end

   // Size register and pointers: a size write empties the buffer
   always_comb begin
      size_in = size_ff;
      wp_in   = wp_ff;
      rp_in   = rp_ff;
      if (csr_write_enable) begin
         if (csr_write_data == '0) begin
            size_in = SIZE_W'(1);
         end else if (WIDE_W'(csr_write_data) > WIDE_W'(DEPTH)) begin
            size_in = SIZE_W'(DEPTH);
         end else begin
            size_in = SIZE_W'(csr_write_data);
         end
         wp_in = '0;
         rp_in = '0;
      end else if (cmd.commit) begin
         wp_in = wp_new;
         rp_in = rp_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_W'(DEPTH);
         wp_ff   <= '0;
         rp_ff   <= '0;
      end else begin
         size_ff <= size_in;
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
      end
   end

   // Result register, loaded on commit only
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         byte_ff <= ((op_ff == OP_PEEK) && ok_ff) ? ram_rd_data : '0;
         rok_ff  <= ok_ff;
         rcnt_ff <= COUNT_W'(avail_new);
         wcnt_ff <= COUNT_W'(free_new);
      end
   end

   assign rsp_read_byte      = byte_ff;
   assign rsp_ok             = rok_ff;
   assign rsp_readable_count = rcnt_ff;
   assign rsp_writable_count = wcnt_ff;

   // Both pointers stay inside the ring in use
   a_wp_range : assert property (@(posedge clock) disable iff (reset)
      SIZE_W'(wp_ff) < size_ff)
      else $error("head pointer outside ring");

   a_rp_range : assert property (@(posedge clock) disable iff (reset)
      SIZE_W'(rp_ff) < size_ff)
      else $error("tail pointer outside ring");

   // The remainder unit never leaves a value at or above the size
   a_rem_range : assert property (@(posedge clock) disable iff (reset)
      cmd.commit && status.needs_div |-> SIZE_W'(rem_ff) < size_ff)
      else $error("pointer load remainder out of range");

endmodule

// ----- hdl/byte_ring_buffer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_ring_buffer
// Byte ring buffer keeping one slot empty, with a configurable ring size,
// write, peek, skip, flush and head/tail pointer loads.
// ----------------------------------------------------------------------------
// Sequence: an accepted transaction is evaluated, then committed to the result
//   register; set head and set tail also run the 16-step remainder unit between.
// No new transaction is accepted until the controller is back in idle after
//   the commit of the previous one.
//   A result held by a stalled receiver delays the next commit.
// Reset: head and tail at 0, ring size 1024; byte storage is not cleared.
// ----------------------------------------------------------------------------
module byte_ring_buffer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [brb_pkg::OP_W-1:0]      req_operation,
   input  logic [brb_pkg::BYTE_W-1:0]    req_data_byte,
   input  logic [brb_pkg::OFFSET_W-1:0]  req_peek_offset,
   input  logic [brb_pkg::AMOUNT_W-1:0]  req_amount,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [brb_pkg::BYTE_W-1:0]    rsp_read_byte,
   output logic                          rsp_ok,
   output logic [brb_pkg::COUNT_W-1:0]   rsp_readable_count,
   output logic [brb_pkg::COUNT_W-1:0]   rsp_writable_count,
   input  logic                          csr_write_enable,
   input  logic [brb_pkg::CSR_W-1:0]     csr_write_data
);
   import brb_pkg::*;

   brb_cmd_type    cmd;
   brb_status_type status;

   // Sequencing
   brb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Pointers, storage and results
   brb_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_operation      (req_operation),
      .req_data_byte      (req_data_byte),
      .req_peek_offset    (req_peek_offset),
      .req_amount         (req_amount),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .rsp_read_byte      (rsp_read_byte),
      .rsp_ok             (rsp_ok),
      .rsp_readable_count (rsp_readable_count),
      .rsp_writable_count (rsp_writable_count)
   );

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the byte ring buffer. A shadow ring predicts every
// response from the accepted transactions; a directed set covers the limits
// and corner cases, then random traffic runs over a range of ring sizes with
// random sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
   import brb_pkg::*;

   localparam int HALF_PERIOD  = 10;
   localparam int RESET_CYCLES = 12;
   localparam int RANDOM_ITEMS = 1400;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PRINT_LIMIT  = 50;

   // Operation codes the block does not define
   localparam logic [OP_W-1:0] OP_RESERVED_A = 3'd6;
   localparam logic [OP_W-1:0] OP_RESERVED_B = 3'd7;

   typedef struct packed {
      logic [BYTE_W-1:0]  read_byte;
      logic               ok;
      logic [COUNT_W-1:0] readable;
      logic [COUNT_W-1:0] writable;
   } ring_status_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_operation = '0;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic [OFFSET_W-1:0] req_peek_offset = '0;
   logic [AMOUNT_W-1:0] req_amount = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [BYTE_W-1:0]   rsp_read_byte;
   logic                rsp_ok;
   logic [COUNT_W-1:0]  rsp_readable_count;
   logic [COUNT_W-1:0]  rsp_writable_count;
   logic                csr_write_enable = 1'b0;
   logic [CSR_W-1:0]    csr_write_data = '0;

   // Shadow ring: storage, which slots hold a written byte, pointers and size
   logic [BYTE_W-1:0] shadow_store [DEPTH];
   bit                shadow_filled [DEPTH];
   int unsigned       shadow_size = DEPTH;
   int unsigned       shadow_head = 0;
   int unsigned       shadow_tail = 0;

   ring_status_type pending_status [$];
   int unsigned     fail_count = 0;
   int unsigned     quiet_cycles = 0;

   byte_ring_buffer u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_data_byte      (req_data_byte),
      .req_peek_offset    (req_peek_offset),
      .req_amount         (req_amount),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_read_byte      (rsp_read_byte),
      .rsp_ok             (rsp_ok),
      .rsp_readable_count (rsp_readable_count),
      .rsp_writable_count (rsp_writable_count),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Bytes held in the shadow ring
   function automatic int unsigned fill_level();
      if (shadow_head >= shadow_tail) begin
         return shadow_head - shadow_tail;
      end
      return shadow_size - shadow_tail + shadow_head;
   endfunction

   // Advance the shadow ring by one transaction and return the status it reports
   function automatic ring_status_type apply_operation(logic [OP_W-1:0] op,
                                                       logic [BYTE_W-1:0] data,
                                                       logic [OFFSET_W-1:0] offset,
                                                       logic [AMOUNT_W-1:0] amount);
      ring_status_type status;
      int unsigned     level;
      int unsigned     step;
      status = '0;
      level  = fill_level();
      case (op)
         OP_WRITE: begin
            if (shadow_size - 1 - level > 0) begin
               shadow_store[PTR_W'(shadow_head)]  = data;
               shadow_filled[PTR_W'(shadow_head)] = 1'b1;
               shadow_head = (shadow_head + 1) % shadow_size;
               status.ok   = 1'b1;
            end
         end
         OP_PEEK: begin
            if (offset < level) begin
               status.read_byte = shadow_store[PTR_W'((shadow_tail + offset) % shadow_size)];
               status.ok        = 1'b1;
            end
         end
         OP_SKIP: begin
            step = (amount > level) ? level : 32'(amount);
            shadow_tail = (shadow_tail + step) % shadow_size;
         end
         OP_FLUSH:    shadow_tail = shadow_head;
         OP_SET_HEAD: shadow_head = amount % shadow_size;
         OP_SET_TAIL: shadow_tail = amount % shadow_size;
         default: ;
      endcase
      level = fill_level();
      status.readable = level[COUNT_W-1:0];
      status.writable = COUNT_W'(shadow_size - 1 - level);
      return status;
   endfunction

   task automatic report_mismatch(input string what);
      fail_count++;
      if (fail_count <= PRINT_LIMIT) begin
         $display("MISMATCH at %0t ns: %s", $time, what);
      end
   endtask

   // Drive one transaction at the falling edge, hold it until accepted, predict it
   task automatic send_transaction(input logic [OP_W-1:0] op,
                                   input logic [BYTE_W-1:0] data,
                                   input logic [OFFSET_W-1:0] offset,
                                   input logic [AMOUNT_W-1:0] amount);
      @(negedge clock);
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_data_byte   <= data;
      req_peek_offset <= offset;
      req_amount      <= amount;
      do @(posedge clock); while (req_stall);
      pending_status.push_back(apply_operation(op, data, offset, amount));
   endtask

   task automatic pause_sender(input int unsigned cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic wait_for_drain();
      pause_sender(1);
      while (pending_status.size() != 0) @(posedge clock);
   endtask

   // Load the ring size once the block is idle; both pointers return to zero
   task automatic set_ring_size(input logic [CSR_W-1:0] value);
      int unsigned slots;
      wait_for_drain();
      repeat (3) @(posedge clock);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      slots = 32'(value);
      if (slots == 0) slots = 1;
      if (slots > DEPTH) slots = DEPTH;
      shadow_size = slots;
      shadow_head = 0;
      shadow_tail = 0;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Pick one transaction from the shadow state so that peeks never land on
   // a slot that was never written
   task automatic send_random_transaction();
      int unsigned         pick;
      int unsigned         level;
      logic [OP_W-1:0]     op;
      logic [OFFSET_W-1:0] offset;
      logic [AMOUNT_W-1:0] amount;
      level  = fill_level();
      pick   = $urandom_range(0, 99);
      offset = OFFSET_W'($urandom_range(0, 1023));
      amount = AMOUNT_W'($urandom_range(0, 65535));
      if (pick < 40) begin
         op = OP_WRITE;
      end else if (pick < 65) begin
         op = OP_PEEK;
         if (level > 0 && $urandom_range(0, 4) != 0) begin
            offset = OFFSET_W'($urandom_range(0, level - 1));
         end
         if (offset < level &&
             !shadow_filled[PTR_W'((shadow_tail + offset) % shadow_size)]) begin
            offset = OFFSET_W'($urandom_range(level, 1023));
         end
      end else if (pick < 77) begin
         op = OP_SKIP;
         if ($urandom_range(0, 3) != 0) amount = AMOUNT_W'($urandom_range(0, level + 2));
      end else if (pick < 81) begin
         op = OP_FLUSH;
      end else if (pick < 86) begin
         op = OP_SET_HEAD;
         if ($urandom_range(0, 1) != 0) begin
            amount = AMOUNT_W'(shadow_tail + $urandom_range(0, level));
         end
      end else if (pick < 93) begin
         op = OP_SET_TAIL;
         if ($urandom_range(0, 1) != 0) begin
            amount = AMOUNT_W'(shadow_tail + $urandom_range(0, level));
         end
      end else begin
         op = $urandom_range(0, 1) ? OP_RESERVED_A : OP_RESERVED_B;
      end
      send_transaction(op, BYTE_W'($urandom_range(0, 255)), offset, amount);
   endtask

   // Empty ring at the reset size, pointer loads at the top of the amount range
   task automatic test_default_ring();
      send_transaction(OP_PEEK, 8'h00, 10'd0, 16'd0);
      send_transaction(OP_WRITE, 8'h00, 10'd0, 16'd0);
      send_transaction(OP_WRITE, 8'hFF, 10'd0, 16'd0);
      send_transaction(OP_PEEK, 8'h00, 10'd0, 16'd0);
      send_transaction(OP_PEEK, 8'h00, 10'd1, 16'd0);
      send_transaction(OP_PEEK, 8'h00, 10'd1023, 16'd0);
      send_transaction(OP_SKIP, 8'h00, 10'd0, 16'hFFFF);
      send_transaction(OP_WRITE, 8'hA5, 10'd0, 16'd0);
      send_transaction(OP_FLUSH, 8'h00, 10'd0, 16'd0);
      send_transaction(OP_SET_HEAD, 8'h00, 10'd0, 16'hFFFF);
      send_transaction(OP_SET_TAIL, 8'h00, 10'd0, 16'hFFFF);
      send_transaction(OP_RESERVED_A, 8'hFF, 10'd1023, 16'hFFFF);
      send_transaction(OP_RESERVED_B, 8'h00, 10'd0, 16'd0);
   endtask

   // Size zero acts as one slot with no capacity; oversize clamps to the depth
   task automatic test_size_limits();
      set_ring_size(11'd0);
      send_transaction(OP_WRITE, 8'h5A, 10'd0, 16'd0);
      send_transaction(OP_PEEK, 8'h00, 10'd0, 16'd0);
      send_transaction(OP_SKIP, 8'h00, 10'd0, 16'd1);
      set_ring_size(11'd2047);
      send_transaction(OP_WRITE, 8'h11, 10'd0, 16'd0);
      send_transaction(OP_PEEK, 8'h00, 10'd0, 16'd0);
   endtask

   // Two slots: the second write finds the ring full and is dropped
   task automatic test_full_ring();
      set_ring_size(11'd2);
      send_transaction(OP_WRITE, 8'h01, 10'd0, 16'd0);
      send_transaction(OP_WRITE, 8'h02, 10'd0, 16'd0);
      send_transaction(OP_PEEK, 8'h00, 10'd0, 16'd0);
      send_transaction(OP_SET_TAIL, 8'h00, 10'd0, 16'd3);
      send_transaction(OP_SET_HEAD, 8'h00, 10'd0, 16'd2);
   endtask

   // Random traffic over a series of ring sizes, sender in bursts with gaps
   task automatic test_random_traffic();
      logic [CSR_W-1:0] sizes [12];
      int unsigned      burst_left;
      int unsigned      count;
      sizes = '{11'd3, 11'd7, 11'd1, 11'd16, 11'd1024, 11'd2, 11'd1025,
                11'd0, 11'd2047, 11'd5, 11'd300, 11'd40};
      sizes[7] = CSR_W'($urandom_range(2, 64));
      sizes[9] = CSR_W'($urandom_range(1, 1024));
      burst_left = $urandom_range(1, 40);
      foreach (sizes[i]) begin
         set_ring_size(sizes[i]);
         count = (shadow_size == 1) ? 40 : RANDOM_ITEMS / 11;
         repeat (count) begin
            send_random_transaction();
            if (burst_left == 0) begin
               pause_sender($urandom_range(1, 15));
               burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 40);
            end else begin
               burst_left--;
            end
         end
      end
   endtask

   // Receiver stall pattern: phases of no stall, random stall and long stall runs
   int unsigned stall_mode = 0;
   int unsigned stall_phase_left = 0;
   int unsigned stall_run = 0;
   always @(negedge clock) begin
      if (stall_phase_left == 0) begin
         stall_mode       = $urandom_range(0, 2);
         stall_phase_left = $urandom_range(20, 200);
      end else begin
         stall_phase_left--;
      end
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= 1'($urandom_range(0, 1));
         default: begin
            if (stall_run == 0) begin
               rsp_stall <= ~rsp_stall;
               stall_run = $urandom_range(1, 25);
            end else begin
               stall_run--;
            end
         end
      endcase
   end

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin : check_responses
      ring_status_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_status.size() == 0) begin
            report_mismatch("response with no transaction outstanding");
         end else begin
            want = pending_status.pop_front();
            if (rsp_read_byte !== want.read_byte)
               report_mismatch($sformatf("read_byte %0h, predicted %0h",
                                         rsp_read_byte, want.read_byte));
            if (rsp_ok !== want.ok)
               report_mismatch($sformatf("ok %0b, predicted %0b", rsp_ok, want.ok));
            if (rsp_readable_count !== want.readable)
               report_mismatch($sformatf("readable_count %0d, predicted %0d",
                                         rsp_readable_count, want.readable));
            if (rsp_writable_count !== want.writable)
               report_mismatch($sformatf("writable_count %0d, predicted %0d",
                                         rsp_writable_count, want.writable));
         end
      end
   end

   // Watchdog: end the run when nothing moves on either channel for too long
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_default_ring();
      test_size_limits();
      test_full_ring();
      test_random_traffic();
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

// ----- byte_ring_buffer.f -----
hdl/brb_pkg.sv
hdl/brb_ram.sv
hdl/brb_ctrl.sv
hdl/brb_datapath.sv
hdl/byte_ring_buffer.sv
tb/sv/testbench.sv
